FILE: hw/rtl/cascaded_biquad_equalizer_defines.svh
// Assertion macros for the cascaded biquad equalizer.
`ifndef CASCADED_BIQUAD_EQUALIZER_DEFINES_SVH
`define CASCADED_BIQUAD_EQUALIZER_DEFINES_SVH
`ifndef ASSERT_OFF
`define CBQ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CBQ_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CBQ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define CBQ_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/cbq_pkg.sv
// Shared constants and types for the cascaded biquad equalizer.
`timescale 1ns / 1ps
`default_nettype none
package cbq_pkg;
   localparam int NUM_SECTIONS = 4;
   localparam int SECT_W       = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
   localparam int SAMPLE_W     = 24;
   localparam int COEF_W       = 16;
   localparam int NUM_TERMS    = 5;
   localparam int OPND_W       = SAMPLE_W + 1;
   localparam int SUM_W        = OPND_W + 3;
   localparam int ACC_W        = 44;
   localparam int FRAC_BITS    = 13;
   localparam int CNT_W        = $clog2(COEF_W);
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 64;

   localparam logic [SECT_W-1:0] LAST_SECT = SECT_W'(NUM_SECTIONS - 1);
   localparam logic [CNT_W-1:0]  CNT_TOP   = CNT_W'(COEF_W - 1);

   localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] Y_MAX    = (ACC_W'(1) << (SAMPLE_W - 1)) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] Y_MIN    = ~Y_MAX;

   localparam logic [CSR_IDX_W-1:0] CSR_FF_ZERO = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FF_ONE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FF_TWO  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FB_ONE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FB_TWO  = 3'd4;

   localparam logic [CSR_DATA_W-1:0] FF_ZERO_RESET = 64'h2008_9B5C_E5D8_4000;

   typedef struct packed {
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] b2;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
   } coef_set_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] x1;
      logic signed [SAMPLE_W-1:0] x2;
      logic signed [SAMPLE_W-1:0] y1;
      logic signed [SAMPLE_W-1:0] y2;
   } hist_row_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic sat;
   } mac_stat_type;
endpackage
`default_nettype wire

FILE: hw/rtl/cbq_mac.sv
// Bit-serial five-term multiply-accumulate with rounding and saturation for one section.
`timescale 1ns / 1ps
`default_nettype none
module cbq_mac (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire cbq_pkg::coef_set_type               coef,
   input  wire logic signed [cbq_pkg::SAMPLE_W-1:0] x_in,
   input  wire cbq_pkg::hist_row_type               hist,
   output cbq_pkg::mac_stat_type                    stat,
   output logic signed [cbq_pkg::SAMPLE_W-1:0]      y_out
);
   logic                                busy_ff, busy_in;
   logic                                fin_ff, fin_in;
   logic                                first_ff, first_in;
   logic [cbq_pkg::CNT_W-1:0]           cnt_ff, cnt_in;
   logic [cbq_pkg::COEF_W-1:0]          c_ff [cbq_pkg::NUM_TERMS];
   logic [cbq_pkg::COEF_W-1:0]          c_in [cbq_pkg::NUM_TERMS];
   logic signed [cbq_pkg::OPND_W-1:0]   op_ff [cbq_pkg::NUM_TERMS];
   logic signed [cbq_pkg::OPND_W-1:0]   op_in [cbq_pkg::NUM_TERMS];
   logic signed [cbq_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic signed [cbq_pkg::SUM_W-1:0]    sum;
   logic signed [cbq_pkg::SUM_W-1:0]    term;
   logic signed [cbq_pkg::ACC_W-1:0]    rnd;
   logic signed [cbq_pkg::ACC_W-1:0]    ys;
   logic                                over, under;

   // MSB first: the sign bit of each coefficient carries negative weight
   always_comb begin
      sum = '0;
      for (int k = 0; k < cbq_pkg::NUM_TERMS; k++) begin
         if (c_ff[k][cbq_pkg::COEF_W-1]) begin
            sum = sum + cbq_pkg::SUM_W'(op_ff[k]);
         end
      end
      term = first_ff ? -sum : sum;
   end

   always_comb begin
      busy_in  = busy_ff;
      fin_in   = 1'b0;
      first_in = first_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      c_in     = c_ff;
      op_in    = op_ff;
      if (start) begin
         busy_in  = 1'b1;
         first_in = 1'b1;
         cnt_in   = cbq_pkg::CNT_TOP;
         acc_in   = '0;
         c_in[0]  = coef.b0;
         c_in[1]  = coef.b1;
         c_in[2]  = coef.b2;
         c_in[3]  = coef.a1;
         c_in[4]  = coef.a2;
         op_in[0] = cbq_pkg::OPND_W'(x_in);
         op_in[1] = cbq_pkg::OPND_W'(hist.x1);
         op_in[2] = cbq_pkg::OPND_W'(hist.x2);
         op_in[3] = -cbq_pkg::OPND_W'(hist.y1);
         op_in[4] = -cbq_pkg::OPND_W'(hist.y2);
      end else if (busy_ff) begin
         acc_in   = (acc_ff <<< 1) + cbq_pkg::ACC_W'(term);
         first_in = 1'b0;
         for (int k = 0; k < cbq_pkg::NUM_TERMS; k++) begin
            c_in[k] = c_ff[k] << 1;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
      end
      first_ff <= first_in;
      cnt_ff   <= cnt_in;
      acc_ff   <= acc_in;
      c_ff     <= c_in;
      op_ff    <= op_in;
   end

   // round half up, then clip to the sample range
   always_comb begin
      rnd   = acc_ff + cbq_pkg::RND_HALF;
      ys    = rnd >>> cbq_pkg::FRAC_BITS;
      over  = ys > cbq_pkg::Y_MAX;
      under = ys < cbq_pkg::Y_MIN;
      if (over) begin
         y_out = cbq_pkg::SAMPLE_W'(cbq_pkg::Y_MAX);
      end else if (under) begin
         y_out = cbq_pkg::SAMPLE_W'(cbq_pkg::Y_MIN);
      end else begin
         y_out = cbq_pkg::SAMPLE_W'(ys);
      end
      stat.busy = busy_ff;
      stat.done = fin_ff;
      stat.sat  = over | under;
   end
endmodule
`default_nettype wire

FILE: hw/rtl/cascaded_biquad_equalizer.sv
// Top level of the cascaded direct-form-I biquad equalizer.
//
//  channel  | ports                                            | direction
//  ---------+--------------------------------------------------+----------
//  req      | req_valid/ready, req_sample_in, req_clear_history | in
//  rsp      | rsp_valid/ready, rsp_sample_out, rsp_saturated    | out
//  csr      | csr_valid/ready, csr_index, csr_wdata             | in
//
// One item at a time: the sections run one after another from transfer to rsp_valid.
// Each section loads the bit-serial MAC, steps through the 16 coefficient bits
// (one bit across all five terms per step), then rounds, clips and rotates.
// The next item is taken once the result has moved into the output register,
// so a new transfer waits for the previous item to finish; an unaccepted result stalls the next.
// Synchronous active-high reset clears histories and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "cascaded_biquad_equalizer_defines.svh"
module cascaded_biquad_equalizer (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic signed [cbq_pkg::SAMPLE_W-1:0]   req_sample_in,
   input  wire logic                                  req_clear_history,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [cbq_pkg::SAMPLE_W-1:0]        rsp_sample_out,
   output logic                                       rsp_saturated,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [cbq_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [cbq_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CALC = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [1:0]                          state_ff, state_in;
   logic [cbq_pkg::SECT_W-1:0]          sect_ff, sect_in;
   logic                                start_ff, start_in;
   logic signed [cbq_pkg::SAMPLE_W-1:0] cur_x_ff, cur_x_in;
   logic                                sat_ff, sat_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [cbq_pkg::SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                                rsp_sat_ff, rsp_sat_in;
   cbq_pkg::hist_row_type               hist_ff [cbq_pkg::NUM_SECTIONS];
   cbq_pkg::hist_row_type               hist_in [cbq_pkg::NUM_SECTIONS];
   cbq_pkg::hist_row_type               new_row;
   logic [cbq_pkg::CSR_DATA_W-1:0]      ff_zero_ff, ff_one_ff, ff_two_ff;
   logic [cbq_pkg::CSR_DATA_W-1:0]      fb_one_ff, fb_two_ff;
   cbq_pkg::coef_set_type               coef;
   cbq_pkg::mac_stat_type               mac_stat;
   logic signed [cbq_pkg::SAMPLE_W-1:0] mac_y;

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_saturated  = rsp_sat_ff;
   assign csr_ready      = 1'b1;

   always_comb begin
      coef.b0 = ff_zero_ff[cbq_pkg::COEF_W * sect_ff +: cbq_pkg::COEF_W];
      coef.b1 = ff_one_ff[cbq_pkg::COEF_W * sect_ff +: cbq_pkg::COEF_W];
      coef.b2 = ff_two_ff[cbq_pkg::COEF_W * sect_ff +: cbq_pkg::COEF_W];
      coef.a1 = fb_one_ff[cbq_pkg::COEF_W * sect_ff +: cbq_pkg::COEF_W];
      coef.a2 = fb_two_ff[cbq_pkg::COEF_W * sect_ff +: cbq_pkg::COEF_W];
   end

   cbq_mac u_mac (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .coef  (coef),
      .x_in  (cur_x_ff),
      .hist  (hist_ff[0]),
      .stat  (mac_stat),
      .y_out (mac_y)
   );

   // histories rotate one row per section; row 0 is always the active one
   always_comb begin
      state_in      = state_ff;
      sect_in       = sect_ff;
      start_in      = 1'b0;
      cur_x_in      = cur_x_ff;
      sat_in        = sat_ff;
      hist_in       = hist_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_sat_in    = rsp_sat_ff;
      new_row.x1    = cur_x_ff;
      new_row.x2    = hist_ff[0].x1;
      new_row.y1    = mac_y;
      new_row.y2    = hist_ff[0].y1;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cur_x_in = req_sample_in;
               sect_in  = '0;
               start_in = 1'b1;
               sat_in   = 1'b0;
               if (req_clear_history) begin
                  for (int i = 0; i < cbq_pkg::NUM_SECTIONS; i++) begin
                     hist_in[i] = '0;
                  end
               end
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (mac_stat.done) begin
               for (int i = 0; i < cbq_pkg::NUM_SECTIONS - 1; i++) begin
                  hist_in[i] = hist_ff[i+1];
               end
               hist_in[cbq_pkg::NUM_SECTIONS-1] = new_row;
               cur_x_in = mac_y;
               sat_in   = sat_ff | mac_stat.sat;
               if (sect_ff == cbq_pkg::LAST_SECT) begin
                  state_in = ST_HOLD;
               end else begin
                  sect_in  = cbq_pkg::SECT_W'(sect_ff + 1'b1);
                  start_in = 1'b1;
               end
            end
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = cur_x_ff;
               rsp_sat_in    = sat_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < cbq_pkg::NUM_SECTIONS; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         hist_ff      <= hist_in;
      end
      sect_ff       <= sect_in;
      cur_x_ff      <= cur_x_in;
      sat_ff        <= sat_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_sat_ff    <= rsp_sat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ff_zero_ff <= cbq_pkg::FF_ZERO_RESET;
         ff_one_ff  <= '0;
         ff_two_ff  <= '0;
         fb_one_ff  <= '0;
         fb_two_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cbq_pkg::CSR_FF_ZERO: ff_zero_ff <= csr_wdata;
            cbq_pkg::CSR_FF_ONE:  ff_one_ff  <= csr_wdata;
            cbq_pkg::CSR_FF_TWO:  ff_two_ff  <= csr_wdata;
            cbq_pkg::CSR_FB_ONE:  fb_one_ff  <= csr_wdata;
            cbq_pkg::CSR_FB_TWO:  fb_two_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   `CBQ_ASSERT_NXT(a_accept_starts, clock, reset, req_valid && req_ready, start_ff, "transfer did not start the MAC")
   `CBQ_ASSERT_IMP(a_start_idle_mac, clock, reset, start_ff, !mac_stat.busy, "MAC started while busy")
   `CBQ_ASSERT_IMP(a_done_in_calc, clock, reset, mac_stat.done, state_ff == ST_CALC, "MAC done outside calc")
   `CBQ_ASSERT_NXT(a_last_to_hold, clock, reset, mac_stat.done && sect_ff == cbq_pkg::LAST_SECT, state_ff == ST_HOLD, "last section did not finish")
endmodule
`default_nettype wire

FILE: tb/biquad_response_checker.sv
// Transfer monitor, coefficient mirror and output prediction for the biquad equalizer.
`timescale 1ns / 1ps
module biquad_response_checker
   import cbq_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   input  logic                       req_clear_history,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic signed [SAMPLE_W-1:0] rsp_sample_out,
   input  logic                       rsp_saturated,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata,
   output int                         failures,
   output int                         outstanding,
   output int                         checked,
   output int                         clipped
);

   localparam longint OUT_MAX = 64'sd8388607;
   localparam longint OUT_MIN = -64'sd8388608;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       saturated;
   } filtered_type;

   logic [CSR_DATA_W-1:0] coef_bank [NUM_TERMS];
   hist_row_type          hist [NUM_SECTIONS];
   filtered_type          pending_samples [$];

   function automatic longint coef_at(input logic [CSR_DATA_W-1:0] word, input int sect);
      return longint'($signed(word[COEF_W*sect +: COEF_W]));
   endfunction

   function automatic void filter_sample(input logic signed [SAMPLE_W-1:0] x_in,
                                         input logic clr, output filtered_type res);
      longint x;
      longint acc;
      longint y;
      int     s;
      res.saturated = 1'b0;
      if (clr)
         for (s = 0; s < NUM_SECTIONS; s++) hist[s] = '0;
      x = longint'(x_in);
      for (s = 0; s < NUM_SECTIONS; s++) begin
         acc = coef_at(coef_bank[CSR_FF_ZERO], s) * x
             + coef_at(coef_bank[CSR_FF_ONE], s) * longint'(hist[s].x1)
             + coef_at(coef_bank[CSR_FF_TWO], s) * longint'(hist[s].x2)
             - coef_at(coef_bank[CSR_FB_ONE], s) * longint'(hist[s].y1)
             - coef_at(coef_bank[CSR_FB_TWO], s) * longint'(hist[s].y2);
         // round half up, then clip
         y = (acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
         if (y > OUT_MAX) begin
            y = OUT_MAX;
            res.saturated = 1'b1;
         end
         if (y < OUT_MIN) begin
            y = OUT_MIN;
            res.saturated = 1'b1;
         end
         hist[s].x2 = hist[s].x1;
         hist[s].x1 = x[SAMPLE_W-1:0];
         hist[s].y2 = hist[s].y1;
         hist[s].y1 = y[SAMPLE_W-1:0];
         x = y;
      end
      res.sample_out = x[SAMPLE_W-1:0];
   endfunction

   always @(posedge clock) begin
      filtered_type want;
      filtered_type got;
      int           s;
      if (reset) begin
         coef_bank[CSR_FF_ZERO] = FF_ZERO_RESET;
         coef_bank[CSR_FF_ONE]  = '0;
         coef_bank[CSR_FF_TWO]  = '0;
         coef_bank[CSR_FB_ONE]  = '0;
         coef_bank[CSR_FB_TWO]  = '0;
         for (s = 0; s < NUM_SECTIONS; s++) hist[s] = '0;
         pending_samples.delete();
         failures = 0;
         checked  = 0;
         clipped  = 0;
      end else begin
         if (csr_valid && csr_ready && csr_index <= CSR_FB_TWO)
            coef_bank[csr_index] = csr_wdata;
         if (rsp_valid && rsp_ready) begin
            if (pending_samples.size() == 0) begin
               $error("unexpected result: sample_out %0d saturated %0b",
                      rsp_sample_out, rsp_saturated);
               failures++;
            end else begin
               want = pending_samples.pop_front();
               checked++;
               if (rsp_saturated) clipped++;
               if (rsp_sample_out !== want.sample_out) begin
                  $error("sample_out: expected %0d, got %0d", want.sample_out, rsp_sample_out);
                  failures++;
               end
               if (rsp_saturated !== want.saturated) begin
                  $error("saturated: expected %0b, got %0b", want.saturated, rsp_saturated);
                  failures++;
               end
            end
         end
         if (req_valid && req_ready) begin
            filter_sample(req_sample_in, req_clear_history, got);
            pending_samples.push_back(got);
         end
      end
      outstanding <= pending_samples.size();
   end

endmodule

FILE: tb/tb_top.sv
// Stimulus, clocking and verdict for the cascaded biquad equalizer testbench.
`timescale 1ns / 1ps
module tb_top;
   import cbq_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int NUM_CHUNKS  = 16;
   localparam int CHUNK_ITEMS = 100;

   typedef enum {SET_STABLE, SET_RAW, SET_HOT} setting_kind_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample_in;
   logic                       req_clear_history;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic                       rsp_saturated;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CSR_DATA_W-1:0]      csr_wdata;

   int failures;
   int outstanding;
   int checked;
   int clipped;
   int cycles = 0;
   int send_idle_pct;
   int recv_idle_pct;
   int items_sent;
   int clears_sent;
   int settings_used;

   cascaded_biquad_equalizer dut (.*);
   biquad_response_checker   u_check (.*);

   initial clock = 1'b0;
   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still due", cycles, outstanding);
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   task automatic send_item(input logic signed [SAMPLE_W-1:0] value, input logic clr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_sample_in     <= value;
      req_clear_history <= clr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (clr) clears_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // a write to an unmapped index follows every set and must be ignored
   task automatic apply_setting(input logic [CSR_DATA_W-1:0] ff0, ff1, ff2, fb1, fb2);
      write_reg(CSR_FF_ZERO, ff0);
      write_reg(CSR_FF_ONE, ff1);
      write_reg(CSR_FF_TWO, ff2);
      write_reg(CSR_FB_ONE, fb1);
      write_reg(CSR_FB_TWO, fb2);
      write_reg(CSR_IDX_W'($urandom_range(2 ** CSR_IDX_W - 1, NUM_TERMS)), {$urandom, $urandom});
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic load_random_setting(input setting_kind_type kind);
      logic [CSR_DATA_W-1:0] word [NUM_TERMS];
      int s;
      int r;
      int a2;
      int lim;
      int gain;
      for (s = 0; s < NUM_SECTIONS; s++) begin
         for (r = 0; r < NUM_TERMS; r++) word[r][COEF_W*s +: COEF_W] = COEF_W'($urandom);
         if (kind == SET_STABLE) begin
            // poles inside the unit circle: |a2| < 1, |a1| < 1 + a2
            a2  = $urandom_range(14000) - 7000;
            lim = 8192 + a2 - 256;
            word[CSR_FF_ZERO][COEF_W*s +: COEF_W] = COEF_W'($urandom_range(16384) - 8192);
            word[CSR_FF_ONE][COEF_W*s +: COEF_W]  = COEF_W'($urandom_range(16384) - 8192);
            word[CSR_FF_TWO][COEF_W*s +: COEF_W]  = COEF_W'($urandom_range(16384) - 8192);
            word[CSR_FB_ONE][COEF_W*s +: COEF_W]  = COEF_W'($urandom_range(2 * lim) - lim);
            word[CSR_FB_TWO][COEF_W*s +: COEF_W]  = COEF_W'(a2);
         end else if (kind == SET_HOT) begin
            gain = $urandom_range(32767, 16384);
            if ($urandom_range(1)) gain = -gain;
            word[CSR_FF_ZERO][COEF_W*s +: COEF_W] = COEF_W'(gain);
            word[CSR_FF_ONE][COEF_W*s +: COEF_W]  = '0;
            word[CSR_FF_TWO][COEF_W*s +: COEF_W]  = '0;
            word[CSR_FB_ONE][COEF_W*s +: COEF_W]  = '0;
            word[CSR_FB_TWO][COEF_W*s +: COEF_W]  = '0;
         end
      end
      apply_setting(word[CSR_FF_ZERO], word[CSR_FF_ONE], word[CSR_FF_TWO],
                    word[CSR_FB_ONE], word[CSR_FB_TWO]);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] rand_sample();
      int pick;
      pick = $urandom_range(7);
      if (pick == 0) begin
         case ($urandom_range(3))
            0:       return 24'sh7FFFFF;
            1:       return 24'sh800000;
            2:       return 24'sh000000;
            default: return 24'shFFFFFF;
         endcase
      end
      if (pick < 3) return SAMPLE_W'($urandom_range(4000) - 2000);
      return SAMPLE_W'($urandom);
   endfunction

   initial begin
      int chunk;
      int n;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_sample_in     = '0;
      req_clear_history = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      send_idle_pct     = 0;
      recv_idle_pct     = 0;
      items_sent        = 0;
      clears_sent       = 0;
      settings_used     = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset coefficients: mixed gains per section, full-scale inputs clip
      send_item(24'sh7FFFFF, 1'b0);
      send_item(24'sh800000, 1'b0);
      send_item(24'sh000000, 1'b0);
      send_item(24'shFFFFFF, 1'b0);
      send_item(24'sd12345, 1'b1);
      wait_drained();

      // half gain in the first section: rounding ties go up
      apply_setting(64'h2000_2000_2000_1000, '0, '0, '0, '0);
      send_item(24'sd1, 1'b0);
      send_item(-24'sd1, 1'b0);
      send_item(24'sd3, 1'b0);
      send_item(-24'sd3, 1'b0);
      wait_drained();

      apply_setting({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}});
      send_item(24'sh7FFFFF, 1'b0);
      send_item(24'sh800000, 1'b0);
      send_item(24'sh7FFFFF, 1'b0);
      wait_drained();

      apply_setting({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
      send_item(24'sh800000, 1'b0);
      send_item(24'sh7FFFFF, 1'b0);
      send_item(24'sd777, 1'b1);
      wait_drained();

      apply_setting('0, '0, '0, '0, '0);
      send_item(24'sh7FFFFF, 1'b0);
      wait_drained();

      apply_setting('1, '1, '1, '1, '1);
      send_item(24'sh800000, 1'b0);
      send_item(24'sh7FFFFF, 1'b0);
      wait_drained();

      for (chunk = 0; chunk < NUM_CHUNKS; chunk++) begin
         if (chunk < 6) begin
            send_idle_pct = 27;
            recv_idle_pct = 84;
         end else if (chunk < 11) begin
            send_idle_pct = 84;
            recv_idle_pct = 27;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (chunk % 4)
            1:       load_random_setting(SET_RAW);
            3:       load_random_setting(SET_HOT);
            default: load_random_setting(SET_STABLE);
         endcase
         for (n = 0; n < CHUNK_ITEMS; n++)
            send_item(rand_sample(), $urandom_range(15) == 0);
         wait_drained();
      end

      repeat (80) @(posedge clock);
      $display("Sent %0d samples (%0d with history clear) over %0d coefficient sets.",
               items_sent, clears_sent, settings_used);
      $display("Checked %0d filtered samples, %0d of them clipped.", checked, clipped);
      if (failures == 0 && outstanding == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/cbq_pkg.sv
hw/rtl/cbq_mac.sv
hw/rtl/cascaded_biquad_equalizer.sv
tb/biquad_response_checker.sv
tb/tb_top.sv
